// ----- design/sbe_pkg.sv -----
// ============================================================================
// sbe_pkg
// Shared widths, register codes, reset values and stage payload types for the
// hat function evaluation pipeline.
// ============================================================================
`default_nettype none

package sbe_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned INDEX_W    = 17;
   localparam int unsigned DIM_W      = 2;
   localparam int unsigned KC_W       = 7;
   localparam int unsigned LEVEL_W    = 5;
   localparam int unsigned SHIFT_W    = 16;
   localparam int unsigned FRAC_W     = 28;
   localparam int unsigned U_W        = FRAC_W + 1;

   localparam int unsigned DIV_STEP   = 4;
   localparam int unsigned DIV_STAGES = (INDEX_W + DIV_STEP - 1) / DIV_STEP;
   localparam int unsigned DIV_W      = DIV_STAGES * DIV_STEP;

   localparam int unsigned DIMENSIONS_DEF    = 2;
   localparam int unsigned MAX_LEVEL_DEF     = 10;
   localparam int unsigned MAX_INTERVALS_DEF = 64;

   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 56;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL_COUNT  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_INTERVAL_LENGTH = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_INVERSE_LENGTH  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROOT_LENGTH     = 2'd3;

   localparam logic [KC_W-1:0]   KC_RESET   = 7'd1;
   localparam logic [TIME_W-1:0] DT_RESET   = 32'h1000_0000;
   localparam logic [TIME_W-1:0] INV_RESET  = 32'h0100_0000;
   localparam logic [TIME_W-1:0] ROOT_RESET = 32'h1000_0000;

   localparam logic [U_W-1:0]    ONE_Q      = U_W'(1) << FRAC_W;
   localparam logic [30:0]       SQRT2_Q30  = 31'd1518500250;
   localparam logic [TIME_W-1:0] SAT_MAX    = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [TIME_W-1:0]  t;
      logic [INDEX_W-1:0] iota;
      logic               q;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]  t;
      logic               q;
      logic [DIM_W-1:0]   dim;
      logic [INDEX_W-1:0] i1;
   } split_type;

   typedef struct packed {
      logic [TIME_W-1:0] t;
      logic              q;
      logic [DIM_W-1:0]  dim;
      logic [DIV_W-1:0]  num;
      logic [KC_W-1:0]   rem;
   } div_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] l;
      logic [SHIFT_W-1:0] j;
      logic [DIM_W-1:0]   dim;
      logic [KC_W-1:0]    k;
   } rep_type;

   typedef struct packed {
      rep_type        rep;
      logic           en;
      logic [U_W-1:0] u;
   } win_type;

   typedef struct packed {
      logic [KC_W-1:0]   kc;
      logic [TIME_W-1:0] dt;
      logic [TIME_W-1:0] inv;
      logic [TIME_W-1:0] root;
   } cfg_type;

endpackage

`default_nettype wire

// ----- design/schauder_basis_eval_core.sv -----
// ============================================================================
// schauder_basis_eval_core
// Pipeline of 2 index split, 5 divider, 5 window and 7 hat and scale stages.
// Throughput: one request per cycle while the response side is ready; each
// stage has its own valid bit, so bubbles collapse under response backpressure.
// Reset clears all valid bits and loads the register defaults (K=1, dt=1.0,
// 1/dt=1.0, sqrt(dt)=1.0); there is no clearing pass.
// ============================================================================
`default_nettype none

module schauder_basis_eval_core #(
   parameter int unsigned DIMENSIONS    = sbe_pkg::DIMENSIONS_DEF,
   parameter int unsigned MAX_LEVEL     = sbe_pkg::MAX_LEVEL_DEF,
   parameter int unsigned MAX_INTERVALS = sbe_pkg::MAX_INTERVALS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbe_pkg::CSR_ADDR_W-1:0]    csr_index,
   input  logic [sbe_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // time_value[31:0], basis_index[48:32], query_dimension[49], zero[55:50]
   input  logic [sbe_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // basis_value[31:0], level[35:32], shift[44:36], index_dimension[45],
   // interval_number[51:46], zero[55:52]
   output logic [sbe_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import sbe_pkg::*;

   cfg_type         cfg_ff, cfg_in;
   logic [KC_W-1:0] kc_wr;

   always_comb begin
      kc_wr = csr_data[KC_W-1:0];
      if (kc_wr == '0) begin
         kc_wr = KC_W'(1);
      end else if (32'(kc_wr) > MAX_INTERVALS) begin
         kc_wr = KC_W'(MAX_INTERVALS);
      end
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERVAL_COUNT:  cfg_in.kc   = kc_wr;
            CSR_INTERVAL_LENGTH: cfg_in.dt   = csr_data;
            CSR_INVERSE_LENGTH:  cfg_in.inv  = csr_data;
            CSR_ROOT_LENGTH:     cfg_in.root = csr_data;
            default:             cfg_in      = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kc   <= KC_RESET;
         cfg_ff.dt   <= DT_RESET;
         cfg_ff.inv  <= INV_RESET;
         cfg_ff.root <= ROOT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   req_type   req;
   split_type split_data;
   div_type   div_data;
   win_type   win_data;
   rep_type   rsp_rep;
   logic [TIME_W-1:0] rsp_value;
   logic split_valid, split_ready, div_valid, div_ready, win_valid, win_ready;

   assign req.t    = req_tdata[31:0];
   assign req.iota = req_tdata[48:32];
   assign req.q    = req_tdata[49];

   sbe_index_split #(
      .DIMENSIONS (DIMENSIONS)
   ) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   sbe_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .kc        (cfg_ff.kc),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   sbe_window #(
      .MAX_LEVEL (MAX_LEVEL)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .kc        (cfg_ff.kc),
      .dt        (cfg_ff.dt),
      .inv       (cfg_ff.inv),
      .in_valid  (div_valid),
      .in_ready  (div_ready),
      .in_data   (div_data),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_data  (win_data)
   );

   sbe_hat u_hat (
      .clock     (clock),
      .reset     (reset),
      .root      (cfg_ff.root),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_data   (win_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_value),
      .out_rep   (rsp_rep)
   );

   assign rsp_tdata = {4'b0000, rsp_rep.k[5:0], rsp_rep.dim[0], rsp_rep.j[8:0],
                       rsp_rep.l[3:0], rsp_value};

endmodule

`default_nettype wire

// ----- design/sbe_index_split.sv -----
// ============================================================================
// sbe_index_split
// Splits the flat index into dimension and the rest by a reciprocal multiply
// and one correction step. Two register stages.
// ============================================================================
`default_nettype none

module sbe_index_split #(
   parameter int unsigned DIMENSIONS = sbe_pkg::DIMENSIONS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  sbe_pkg::req_type    in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output sbe_pkg::split_type  out_data
);
   import sbe_pkg::*;

   localparam int unsigned NS       = 2;
   localparam int unsigned RECIP_SH = INDEX_W + 3;
   localparam int unsigned RECIP_W  = RECIP_SH + 1;
   localparam int unsigned PROD_W   = INDEX_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH) / DIMENSIONS);
   localparam logic [INDEX_W-1:0] DIM_K = INDEX_W'(DIMENSIONS);

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NS; i++) v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: estimate of index / DIMENSIONS, low by at most one
   req_type            s1_req_ff;
   logic [INDEX_W-1:0] s1_quo_ff, s1_quo_in;
   logic [PROD_W-1:0]  s1_prod;

   always_comb begin
      s1_prod   = PROD_W'(in_data.iota) * PROD_W'(RECIP);
      s1_quo_in = s1_prod[RECIP_SH +: INDEX_W];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_req_ff <= in_data;
         s1_quo_ff <= s1_quo_in;
      end
   end

   // stage 2: correct estimate, remainder is the dimension
   split_type          s2_ff, s2_in;
   logic [INDEX_W-1:0] s2_rem;
   logic               s2_fix;

   always_comb begin
      s2_rem   = s1_req_ff.iota - s1_quo_ff * DIM_K;
      s2_fix   = s2_rem >= DIM_K;
      s2_in.t  = s1_req_ff.t;
      s2_in.q  = s1_req_ff.q;
      s2_in.dim = s2_fix ? DIM_W'(s2_rem - DIM_K) : DIM_W'(s2_rem);
      s2_in.i1 = s1_quo_ff + INDEX_W'(s2_fix);
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_ff <= s2_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

// ----- design/sbe_divider.sv -----
// ============================================================================
// sbe_divider
// Pipelined restoring divider of the index rest by the interval count,
// DIV_STEP quotient bits per stage.
// ============================================================================
`default_nettype none

module sbe_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbe_pkg::KC_W-1:0]      kc,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sbe_pkg::split_type            in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output sbe_pkg::div_type              out_data
);
   import sbe_pkg::*;

   localparam int unsigned NS = DIV_STAGES;

   function automatic div_type div_step(div_type x, logic [KC_W-1:0] d);
      div_type     y;
      logic [KC_W:0] trial;
      y = x;
      for (int b = 0; b < DIV_STEP; b++) begin
         trial = {y.rem, y.num[DIV_W-1]};
         y.num = {y.num[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, d}) begin
            y.rem    = KC_W'(trial - {1'b0, d});
            y.num[0] = 1'b1;
         end else begin
            y.rem = trial[KC_W-1:0];
         end
      end
      return y;
   endfunction

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NS; i++) v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   div_type st_ff [NS];
   div_type st_in [NS];
   div_type init;

   always_comb begin
      init.t   = in_data.t;
      init.q   = in_data.q;
      init.dim = in_data.dim;
      init.num = DIV_W'(in_data.i1);
      init.rem = '0;
      st_in[0] = div_step(init, kc);
      for (int s = 1; s < NS; s++) st_in[s] = div_step(st_ff[s-1], kc);
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NS; s++) begin
         if (adv[s]) st_ff[s] <= st_in[s];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = st_ff[NS-1];

endmodule

`default_nettype wire

// ----- design/sbe_window.sv -----
// ============================================================================
// sbe_window
// Level and shift decode, interval window test and rescaling of the time
// into the interval. Five register stages.
// ============================================================================
`default_nettype none

module sbe_window #(
   parameter int unsigned MAX_LEVEL = sbe_pkg::MAX_LEVEL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbe_pkg::KC_W-1:0]      kc,
   input  logic [sbe_pkg::TIME_W-1:0]    dt,
   input  logic [sbe_pkg::TIME_W-1:0]    inv,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sbe_pkg::div_type              in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output sbe_pkg::win_type              out_data
);
   import sbe_pkg::*;

   localparam int unsigned NS      = 5;
   localparam int unsigned START_W = TIME_W + KC_W;
   localparam int unsigned PROD_W  = 2 * TIME_W;

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NS; i++) v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: interval number, leading one, level and shift
   rep_type           w1_rep_ff, w1_rep_in;
   logic [TIME_W-1:0] w1_t_ff;
   logic              w1_sel_ff, w1_sel_in;
   logic [LEVEL_W-1:0] w1_pos, w1_lvl;
   logic [DIV_W-1:0]  w1_rest;
   logic              w1_nz, w1_deep;

   always_comb begin
      w1_pos = '0;
      for (int b = 0; b < DIV_W; b++) begin
         if (in_data.num[b]) w1_pos = LEVEL_W'(b);
      end
      w1_nz   = |in_data.num;
      w1_lvl  = w1_pos + LEVEL_W'(1);
      w1_deep = w1_nz && (w1_lvl > LEVEL_W'(MAX_LEVEL));
      w1_rest = in_data.num & ~(DIV_W'(1) << w1_pos);
      w1_rep_in.dim = in_data.dim;
      w1_rep_in.k   = kc - KC_W'(1) - in_data.rem;
      if (w1_nz && !w1_deep) begin
         w1_rep_in.l = w1_lvl;
         w1_rep_in.j = w1_rest[SHIFT_W-1:0];
      end else begin
         w1_rep_in.l = '0;
         w1_rep_in.j = '0;
      end
      w1_sel_in = !w1_deep && (in_data.dim == DIM_W'(in_data.q));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         w1_rep_ff <= w1_rep_in;
         w1_t_ff   <= in_data.t;
         w1_sel_ff <= w1_sel_in;
      end
   end

   // stage 2: interval start k*dt
   rep_type            w2_rep_ff;
   logic [TIME_W-1:0]  w2_t_ff;
   logic               w2_sel_ff;
   logic [START_W-1:0] w2_start_ff, w2_start_in;

   assign w2_start_in = START_W'(w1_rep_ff.k) * START_W'(dt);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         w2_rep_ff   <= w1_rep_ff;
         w2_t_ff     <= w1_t_ff;
         w2_sel_ff   <= w1_sel_ff;
         w2_start_ff <= w2_start_in;
      end
   end

   // stage 3: window compares and offset into the interval
   rep_type           w3_rep_ff;
   logic              w3_en_ff, w3_en_in;
   logic              w3_full_ff, w3_full_in;
   logic [TIME_W-1:0] w3_diff_ff, w3_diff_in;
   logic [START_W:0]  w3_stop;

   always_comb begin
      w3_stop    = (START_W + 1)'(w2_start_ff) + (START_W + 1)'(dt);
      w3_en_in   = w2_sel_ff && (w2_start_ff <= START_W'(w2_t_ff));
      w3_full_in = w3_stop < (START_W + 1)'(w2_t_ff);
      w3_diff_in = w2_t_ff - w2_start_ff[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         w3_rep_ff  <= w2_rep_ff;
         w3_en_ff   <= w3_en_in;
         w3_full_ff <= w3_full_in;
         w3_diff_ff <= w3_diff_in;
      end
   end

   // stage 4: offset times reciprocal
   rep_type           w4_rep_ff;
   logic              w4_en_ff, w4_full_ff;
   logic [PROD_W-1:0] w4_prod_ff, w4_prod_in;

   assign w4_prod_in = PROD_W'(w3_diff_ff) * PROD_W'(inv);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         w4_rep_ff  <= w3_rep_ff;
         w4_en_ff   <= w3_en_ff;
         w4_full_ff <= w3_full_ff;
         w4_prod_ff <= w4_prod_in;
      end
   end

   // stage 5: round to Q.28 and clamp to one
   win_type               w5_ff, w5_in;
   logic [PROD_W-23-1:0]  w5_sum;

   always_comb begin
      w5_sum    = (PROD_W - 23)'(w4_prod_ff[PROD_W-1:23]) + (PROD_W - 23)'(1);
      w5_in.rep = w4_rep_ff;
      w5_in.en  = w4_en_ff;
      if (w4_full_ff || (w5_sum[PROD_W-23-1:1] > (PROD_W - 24)'(ONE_Q))) begin
         w5_in.u = ONE_Q;
      end else begin
         w5_in.u = w5_sum[U_W:1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         w5_ff <= w5_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_data  = w5_ff;

endmodule

`default_nettype wire

// ----- design/sbe_hat.sv -----
// ============================================================================
// sbe_hat
// Hat function of level and shift at the rescaled time, half-power scaling,
// final multiply by sqrt(dt), rounding and saturation. Seven register stages,
// the last one is the response register.
// ============================================================================
`default_nettype none

module sbe_hat (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sbe_pkg::TIME_W-1:0]    root,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  sbe_pkg::win_type              in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [sbe_pkg::TIME_W-1:0]    out_value,
   output sbe_pkg::rep_type              out_rep
);
   import sbe_pkg::*;

   localparam int unsigned NS    = 7;
   localparam int unsigned HS_W  = U_W + 8;
   localparam int unsigned PR_W  = U_W + 31;
   localparam int unsigned VAL_W = U_W + TIME_W;

   logic [NS-1:0] v_ff, v_in, adv;

   always_comb begin
      adv[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS - 2; i >= 0; i--) adv[i] = !v_ff[i] || adv[i+1];
      v_in[0] = adv[0] ? in_valid : v_ff[0];
      for (int i = 1; i < NS; i++) v_in[i] = adv[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // stage 1: breakpoints of the hat
   win_type        h1_win_ff;
   logic [3:0]     h1_e_ff, h1_e_in;
   logic [U_W-1:0] h1_tmin_ff, h1_tmin_in;
   logic [U_W-1:0] h1_tmid_ff, h1_tmid_in;
   logic [U_W-1:0] h1_tmax_ff, h1_tmax_in;
   logic [4:0]     h1_sh_hi, h1_sh_lo;

   always_comb begin
      h1_e_in    = 4'(in_data.rep.l - LEVEL_W'(1));
      h1_sh_hi   = 5'd28 - 5'(h1_e_in);
      h1_sh_lo   = 5'd27 - 5'(h1_e_in);
      h1_tmin_in = U_W'(in_data.rep.j) << h1_sh_hi;
      h1_tmid_in = U_W'({in_data.rep.j, 1'b1}) << h1_sh_lo;
      h1_tmax_in = (U_W'(in_data.rep.j) + U_W'(1)) << h1_sh_hi;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         h1_win_ff  <= in_data;
         h1_e_ff    <= h1_e_in;
         h1_tmin_ff <= h1_tmin_in;
         h1_tmid_ff <= h1_tmid_in;
         h1_tmax_ff <= h1_tmax_in;
      end
   end

   // stage 2: 2 min(tmid,u) - min(tmin,u) - min(tmax,u)
   win_type        h2_win_ff;
   logic [3:0]     h2_e_ff;
   logic [U_W-1:0] h2_h_ff, h2_h_in;
   logic [U_W-1:0] h2_a, h2_b, h2_c;
   logic [U_W:0]   h2_sum;

   always_comb begin
      h2_a    = (h1_tmid_ff < h1_win_ff.u) ? h1_tmid_ff : h1_win_ff.u;
      h2_b    = (h1_tmin_ff < h1_win_ff.u) ? h1_tmin_ff : h1_win_ff.u;
      h2_c    = (h1_tmax_ff < h1_win_ff.u) ? h1_tmax_ff : h1_win_ff.u;
      h2_sum  = {h2_a, 1'b0} - (U_W + 1)'(h2_b) - (U_W + 1)'(h2_c);
      h2_h_in = h2_sum[U_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         h2_win_ff <= h1_win_ff;
         h2_e_ff   <= h1_e_ff;
         h2_h_ff   <= h2_h_in;
      end
   end

   // stage 3: integer part of the half power
   win_type        h3_win_ff;
   logic           h3_odd_ff;
   logic [U_W-1:0] h3_hs_ff, h3_hs_in;
   logic [HS_W-1:0] h3_wide;

   always_comb begin
      h3_wide  = HS_W'(h2_h_ff) << h2_e_ff[3:1];
      h3_hs_in = h3_wide[U_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         h3_win_ff <= h2_win_ff;
         h3_odd_ff <= h2_e_ff[0];
         h3_hs_ff  <= h3_hs_in;
      end
   end

   // stage 4: times sqrt(2) for odd exponent
   win_type         h4_win_ff;
   logic            h4_odd_ff;
   logic [U_W-1:0]  h4_hs_ff;
   logic [PR_W-1:0] h4_prod_ff, h4_prod_in;

   assign h4_prod_in = PR_W'(h3_hs_ff) * PR_W'(SQRT2_Q30);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         h4_win_ff  <= h3_win_ff;
         h4_odd_ff  <= h3_odd_ff;
         h4_hs_ff   <= h3_hs_ff;
         h4_prod_ff <= h4_prod_in;
      end
   end

   // stage 5: select hat value
   rep_type         h5_rep_ff;
   logic [U_W-1:0]  h5_psi_ff, h5_psi_in;
   logic [PR_W-1:0] h5_rnd;

   always_comb begin
      h5_rnd = h4_prod_ff + (PR_W'(1) << 29);
      if (!h4_win_ff.en) begin
         h5_psi_in = '0;
      end else if (h4_win_ff.rep.l == '0) begin
         h5_psi_in = h4_win_ff.u;
      end else if (h4_odd_ff) begin
         h5_psi_in = h5_rnd[30 +: U_W];
      end else begin
         h5_psi_in = h4_hs_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         h5_rep_ff <= h4_win_ff.rep;
         h5_psi_ff <= h5_psi_in;
      end
   end

   // stage 6: times sqrt(dt)
   rep_type          h6_rep_ff;
   logic [VAL_W-1:0] h6_prod_ff, h6_prod_in;

   assign h6_prod_in = VAL_W'(h5_psi_ff) * VAL_W'(root);

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         h6_rep_ff  <= h5_rep_ff;
         h6_prod_ff <= h6_prod_in;
      end
   end

   // stage 7: round to Q.28, saturate
   rep_type           h7_rep_ff;
   logic [TIME_W-1:0] h7_val_ff, h7_val_in;
   logic [VAL_W:0]    h7_rnd;
   logic [VAL_W-FRAC_W:0] h7_q;

   always_comb begin
      h7_rnd    = (VAL_W + 1)'(h6_prod_ff) + ((VAL_W + 1)'(1) << (FRAC_W - 1));
      h7_q      = h7_rnd[VAL_W:FRAC_W];
      h7_val_in = (h7_q > (VAL_W - FRAC_W + 1)'(SAT_MAX)) ? SAT_MAX : h7_q[TIME_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         h7_rep_ff <= h6_rep_ff;
         h7_val_ff <= h7_val_in;
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = v_ff[NS-1];
   assign out_value = h7_val_ff;
   assign out_rep   = h7_rep_ff;

endmodule

`default_nettype wire
